@@ sv/normalized_heat_colormap_macros.svh @@
// Assertion macros shared by the heat colormap RTL files.
`ifndef NORMALIZED_HEAT_COLORMAP_MACROS_SVH
`define NORMALIZED_HEAT_COLORMAP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define NHC_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define NHC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/nhc_pkg.sv @@
// Package with the shared types and constants of the heat colormap block.
`default_nettype none

package nhc_pkg;

    // Number of quotient bits of the normalized level (0 to 1024).
    localparam int QUO_BITS = 11;

    // Full scale of a color channel, meaning 1.0.
    localparam logic [QUO_BITS-1:0] FULL_SCALE = 11'd1024;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_READ   = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MEM,
        ST_DIV,
        ST_OUT
    } t_state;

    // Per-transfer controls from the sequencer to the frame store.
    typedef struct packed {
        logic clear;
        logic append;
        logic rd_en;
    } t_frame_ctl;

endpackage

`default_nettype wire

@@ sv/nhc_frame.sv @@
// Frame store: sample memory, fill count and running peak.
`default_nettype none
`include "normalized_heat_colormap_macros.svh"

module nhc_frame #(
    parameter int PIXELS      = 4096,
    parameter int SAMPLE_BITS = 16,
    parameter int AW          = (PIXELS > 1) ? $clog2(PIXELS) : 1,
    parameter int CW          = $clog2(PIXELS + 1)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire nhc_pkg::t_frame_ctl    i_ctl,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    input  wire logic [AW-1:0]          i_rd_addr,
    output logic      [SAMPLE_BITS-1:0] o_rd_data,
    output logic      [CW-1:0]          o_count,
    output logic      [SAMPLE_BITS-1:0] o_peak
);
    import nhc_pkg::*;

    logic [SAMPLE_BITS-1:0] r_mem [PIXELS];
    logic [SAMPLE_BITS-1:0] r_rd_data;
    logic [CW-1:0]          r_count;
    logic [SAMPLE_BITS-1:0] r_peak;
    logic                   room;

    assign room = (r_count < CW'(PIXELS));

    always_ff @(posedge i_clk) begin
        if (i_ctl.append && room) begin
            r_mem[r_count[AW-1:0]] <= i_sample;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_peak  <= '0;
        end else if (i_ctl.clear) begin
            r_count <= '0;
            r_peak  <= '0;
        end else if (i_ctl.append && room) begin
            r_count <= r_count + CW'(1);
            if (i_sample > r_peak) begin
                r_peak <= i_sample;
            end
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_count   = r_count;
    assign o_peak    = r_peak;

    `NHC_ASSERT(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(PIXELS), "fill count overflow")
    `NHC_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n, i_ctl.clear, r_count == '0 && r_peak == '0, "clear left state")
    `NHC_ASSERT(a_empty_no_peak, i_clk, i_rst_n, r_count == '0, r_peak == '0, "peak set on empty frame")

endmodule

`default_nettype wire

@@ sv/nhc_div.sv @@
// Restoring divider that yields the normalized level one quotient bit per cycle.
`default_nettype none

module nhc_div #(
    parameter int W = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [W-1:0]                 i_num,
    input  wire logic [W-1:0]                 i_den,
    output logic                              o_done,
    output logic      [nhc_pkg::QUO_BITS-1:0] o_quo
);
    import nhc_pkg::*;

    localparam int CNTW = $clog2(QUO_BITS);

    logic [W:0]          r_rem;
    logic [W-1:0]        r_den;
    logic [QUO_BITS-1:0] r_q;
    logic [CNTW-1:0]     r_cnt;
    logic                r_busy;
    logic                r_done;
    logic                ge;
    logic [W:0]          diff;
    logic [W:0]          nxt;

    // The numerator never exceeds the divisor, so the remainder stays below
    // twice the divisor and the first step yields the integer bit.
    always_comb begin
        diff = r_rem - {1'b0, r_den};
        ge   = (r_rem >= {1'b0, r_den});
        nxt  = ge ? diff : r_rem;
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num};
            r_den <= i_den;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= {nxt[W-1:0], 1'b0};
            r_q   <= {r_q[QUO_BITS-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(QUO_BITS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

`default_nettype wire

@@ sv/normalized_heat_colormap.sv @@
// Top level of the heat colormap block with peak normalization.
//
// The input channel (i_in_valid / o_in_ready) carries a command, a pixel index
// and an intensity. A clear command empties the frame and zeroes the peak; an
// append command stores the intensity in the next free slot and raises the
// peak. Both finish in the cycle of their transfer and produce no result.
// A read command produces one result on the output channel (o_out_valid /
// i_out_ready): red, green and blue on a 0 to 1024 scale, a hit flag and the
// peak in force when the read was accepted.
// A read that hits passes through the memory state, the divide state (eleven
// quotient bits, then the done flag) and the output state, where its result
// is registered; the input is not ready again before that, so the block
// takes no new command while a read is in progress.
// A read that misses (index at or beyond the fill count, or zero peak) skips
// the memory and the divider for the output state. The divider sets the rate.
// The result sits in an output register, so the next command can be taken
// while the receiver stalls; a further read then waits in its last state
// until the output register is free. Reset empties the frame and zeroes the
// peak; the memory itself is not cleared, since only filled slots are read.
`default_nettype none
`include "normalized_heat_colormap_macros.svh"

module normalized_heat_colormap #(
    parameter int PIXELS      = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_command,
    input  wire logic [11:0] i_pixel_index,
    input  wire logic [15:0] i_intensity,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic      [10:0] o_red,
    output logic      [10:0] o_green,
    output logic      [10:0] o_blue,
    output logic             o_index_valid,
    output logic      [15:0] o_peak_value
);
    import nhc_pkg::*;

    localparam int AW   = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int CW   = $clog2(PIXELS + 1);
    localparam int CMPW = (CW > 12) ? CW : 12;

    t_state                 r_state, n_state;
    t_frame_ctl             ctl;
    logic                   accept;
    logic                   hit;
    logic                   div_start;
    logic                   div_done;
    logic [QUO_BITS-1:0]    div_quo;
    logic                   load_out;
    logic [SAMPLE_BITS-1:0] rd_data;
    logic [CW-1:0]          count;
    logic [SAMPLE_BITS-1:0] peak;
    logic [CMPW-1:0]        idx_ext;

    logic                   r_hit;
    logic [QUO_BITS-1:0]    r_x;
    logic [15:0]            r_peak_cap;
    logic                   r_out_valid;
    logic [10:0]            r_red, r_green, r_blue;
    logic                   r_index_valid;
    logic [15:0]            r_peak_value;

    logic [QUO_BITS-1:0]    x_sat;
    logic [11:0]            x2;
    logic [11:0]            g_raw;
    logic [12:0]            b_raw;
    logic [10:0]            red, green, blue;

    assign accept  = i_in_valid && o_in_ready;
    assign idx_ext = CMPW'(i_pixel_index);
    assign hit     = (idx_ext < CMPW'(count)) && (idx_ext < CMPW'(PIXELS)) && (peak != '0);

    nhc_frame #(
        .PIXELS      (PIXELS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .AW          (AW),
        .CW          (CW)
    ) u_frame (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_sample  (SAMPLE_BITS'(i_intensity)),
        .i_rd_addr (idx_ext[AW-1:0]),
        .o_rd_data (rd_data),
        .o_count   (count),
        .o_peak    (peak)
    );

    nhc_div #(
        .W (SAMPLE_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (rd_data),
        .i_den   (peak),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Sequencer: clear and append complete at their transfer; a read walks through the
    // memory access and the divide (on a hit only) and the output register load.
    always_comb begin
        n_state    = r_state;
        ctl        = '0;
        o_in_ready = 1'b0;
        div_start  = 1'b0;
        load_out   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (i_command)
                        CMD_CLEAR:  ctl.clear  = 1'b1;
                        CMD_APPEND: ctl.append = 1'b1;
                        CMD_READ: begin
                            ctl.rd_en = hit;
                            n_state   = hit ? ST_MEM : ST_OUT;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MEM: begin
                div_start = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                load_out = !r_out_valid || i_out_ready;
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Per-read context: hit flag, normalized level and the captured peak.
    always_ff @(posedge i_clk) begin
        if (accept && i_command == CMD_READ) begin
            r_hit      <= hit;
            r_peak_cap <= 16'(peak);
            if (!hit) begin
                r_x <= '0;
            end
        end else if (r_state == ST_DIV && div_done) begin
            r_x <= div_quo;
        end
    end

    // Heat ramp: red rises over the lower half, green over the upper half,
    // blue over the top quarter.
    always_comb begin
        x_sat = (r_x > FULL_SCALE) ? FULL_SCALE : r_x;
        x2    = {x_sat, 1'b0};
        g_raw = x2 - 12'd1024;
        b_raw = {x_sat, 2'b00} - 13'd3072;
        red   = (x2 > 12'(FULL_SCALE)) ? FULL_SCALE : x2[10:0];
        green = '0;
        blue  = '0;
        if (x_sat > 11'd512) begin
            green = (g_raw > 12'(FULL_SCALE)) ? FULL_SCALE : g_raw[10:0];
        end
        if (x_sat > 11'd768) begin
            blue = (b_raw > 13'(FULL_SCALE)) ? FULL_SCALE : b_raw[10:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_red         <= red;
            r_green       <= green;
            r_blue        <= blue;
            r_index_valid <= r_hit;
            r_peak_value  <= r_peak_cap;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_red         = r_red;
    assign o_green       = r_green;
    assign o_blue        = r_blue;
    assign o_index_valid = r_index_valid;
    assign o_peak_value  = r_peak_value;

    `NHC_ASSERT(a_miss_black, i_clk, i_rst_n, o_out_valid && !o_index_valid, o_red == '0 && o_green == '0 && o_blue == '0, "miss with color")
    `NHC_ASSERT(a_ramp_order, i_clk, i_rst_n, o_out_valid, o_green <= o_red && o_blue <= o_green, "channels out of ramp order")
    `NHC_ASSERT(a_done_in_div, i_clk, i_rst_n, div_done, r_state == ST_DIV, "divide finished outside divide state")

endmodule

`default_nettype wire

@@ bench/normalized_heat_colormap_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the heat colormap block with peak normalization.
module normalized_heat_colormap_test;
    import nhc_pkg::*;

    // Frame depth of the block as built with its default parameters.
    localparam int FRAME_SLOTS = 4096;
    // Number of counted transfers in the random part.
    localparam int RANDOM_ITEMS = 1900;
    // The run is abandoned once this many clock cycles have gone by.
    localparam int CYCLE_LIMIT = 1_000_000;
    // Only the first few mismatches are printed, the rest are counted.
    localparam int MAX_REPORTS = 10;
    // The one command code that the block ignores.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // One color result as it leaves the block.
    typedef struct packed {
        logic [10:0] red;
        logic [10:0] green;
        logic [10:0] blue;
        logic        hit;
        logic [15:0] peak;
    } t_heat_color;

    // The scoreboard keeps its own copy of the frame, the fill count and the
    // peak. Every accepted read pushes the color that it must produce, and
    // every result on the output channel is checked against the oldest one.
    class heat_scoreboard;
        logic [15:0] frame [FRAME_SLOTS];
        int unsigned fill;
        logic [15:0] peak;
        t_heat_color pending_q[$];
        int unsigned errors;

        function new();
            fill = 0;
            peak = '0;
            errors = 0;
        endfunction

        function int unsigned cap_channel(int unsigned level);
            return (level > FULL_SCALE) ? FULL_SCALE : level;
        endfunction

        function void note_transfer(logic [1:0] cmd, logic [11:0] index, logic [15:0] sample);
            t_heat_color color;
            int unsigned x;
            case (cmd)
                CMD_CLEAR: begin
                    fill = 0;
                    peak = '0;
                end
                CMD_APPEND: begin
                    // A full frame drops the sample and leaves the peak alone.
                    if (fill < FRAME_SLOTS) begin
                        frame[fill] = sample;
                        fill++;
                        if (sample > peak)
                            peak = sample;
                    end
                end
                CMD_READ: begin
                    color = '0;
                    color.peak = peak;
                    if (index < fill && peak != 0) begin
                        x = (32'(frame[index]) * FULL_SCALE) / peak;
                        if (x > FULL_SCALE)
                            x = FULL_SCALE;
                        color.red = 11'(cap_channel(2 * x));
                        if (x > 512)
                            color.green = 11'(cap_channel(2 * x - 1024));
                        if (x > 768)
                            color.blue = 11'(cap_channel(4 * x - 3072));
                        color.hit = 1'b1;
                    end
                    pending_q.push_back(color);
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_heat_color got);
            t_heat_color want;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $write("color result with no read waiting:");
                    $display(" r=%0d g=%0d b=%0d hit=%0d peak=%0d",
                             got.red, got.green, got.blue, got.hit, got.peak);
                end
                return;
            end
            want = pending_q.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $write("color mismatch: expected r=%0d g=%0d b=%0d hit=%0d peak=%0d,",
                           want.red, want.green, want.blue, want.hit, want.peak);
                    $display(" got r=%0d g=%0d b=%0d hit=%0d peak=%0d",
                             got.red, got.green, got.blue, got.hit, got.peak);
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_command;
    logic [11:0] i_pixel_index;
    logic [15:0] i_intensity;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [10:0] o_red;
    logic [10:0] o_green;
    logic [10:0] o_blue;
    logic        o_index_valid;
    logic [15:0] o_peak_value;

    heat_scoreboard sb;
    // Chance in percent that the sender idles before a transfer, and that the
    // receiver stalls in a given cycle.
    int unsigned in_idle_pct;
    int unsigned out_stall_pct;
    int unsigned cycles = 0;

    normalized_heat_colormap i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_pixel_index (i_pixel_index),
        .i_intensity   (i_intensity),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_index_valid (o_index_valid),
        .o_peak_value  (o_peak_value)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Both channels are sampled at the rising edge, before any register of the
    // block takes its new value, so a transfer is seen exactly at the edge that
    // completes it. The receiver's ready is redrawn every cycle.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                sb.note_transfer(i_command, i_pixel_index, i_intensity);
            if (o_out_valid && i_out_ready)
                sb.check_result(t_heat_color'{red: o_red, green: o_green, blue: o_blue,
                                              hit: o_index_valid, peak: o_peak_value});
        end
        i_out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    // Offers one command and returns at the edge where it is taken. Valid is
    // left high afterwards; the next call lowers it only if it idles first.
    task automatic send_item(input logic [1:0] cmd, input logic [11:0] index,
                             input logic [15:0] sample);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_pixel_index <= index;
        i_intensity   <= sample;
        do
            @(posedge i_clk);
        while (!o_in_ready);
    endtask

    // Holds the sender off until every read issued so far has produced its
    // color. Polling on the falling edge keeps clear of the scoreboard update.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending_q.size() != 0)
            @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // Intensities that land on the interesting parts of the color ramp: the
    // full range, tiny values, values near the running base and its half,
    // quarter and three quarters, and the extremes.
    function automatic logic [15:0] pick_intensity(int unsigned base);
        case ($urandom_range(4))
            0: return 16'($urandom);
            1: return 16'($urandom_range(15));
            2: return 16'((base >> $urandom_range(2)) ^ $urandom_range(3));
            3: return 16'((base * 3) / 4 + $urandom_range(3));
            default: return $urandom_range(1) ? 16'hFFFF : 16'($urandom_range(2));
        endcase
    endfunction

    // Directed part: empty frame, zero peak, the thresholds of green and blue,
    // the full-scale sample, reads at and past the fill count, the ignored
    // command and a read after a clear.
    task automatic run_directed();
        send_item(CMD_READ, 12'd0, 16'd0);
        send_item(CMD_APPEND, 12'd0, 16'd0);
        send_item(CMD_READ, 12'd0, 16'd0);
        send_item(CMD_APPEND, 12'hFFF, 16'hFFFF);
        send_item(CMD_APPEND, 12'd0, 16'd32768);
        send_item(CMD_APPEND, 12'd0, 16'd32832);
        send_item(CMD_APPEND, 12'd0, 16'd49152);
        send_item(CMD_APPEND, 12'd0, 16'd49216);
        send_item(CMD_APPEND, 12'd0, 16'd1);
        for (int i = 0; i < 7; i++)
            send_item(CMD_READ, 12'(i), 16'hFFFF);
        send_item(CMD_READ, 12'd7, 16'd0);
        send_item(CMD_READ, 12'hFFF, 16'd0);
        send_item(CMD_UNUSED, 12'hFFF, 16'hFFFF);
        send_item(CMD_READ, 12'd1, 16'd0);
        send_item(CMD_CLEAR, 12'hFFF, 16'hFFFF);
        send_item(CMD_READ, 12'd1, 16'd0);
        send_item(CMD_APPEND, 12'd0, 16'hFFFF);
        send_item(CMD_READ, 12'd0, 16'd0);
    endtask

    // Fills every slot, then appends a sample above the peak that a full frame
    // must drop, and reads the top slot and a spread of others.
    task automatic run_full_frame();
        send_item(CMD_CLEAR, 12'($urandom), 16'($urandom));
        for (int n = 0; n < FRAME_SLOTS; n++)
            send_item(CMD_APPEND, 12'($urandom), 16'($urandom_range(60000, 1)));
        send_item(CMD_APPEND, 12'($urandom), 16'hFFFF);
        send_item(CMD_READ, 12'hFFF, 16'($urandom));
        send_item(CMD_READ, 12'd0, 16'($urandom));
        repeat (20)
            send_item(CMD_READ, 12'($urandom), 16'($urandom));
        send_item(CMD_CLEAR, 12'($urandom), 16'($urandom));
    endtask

    // Random part. Most bursts are a run of appends followed by reads into the
    // filled slots, with some reads past the fill count; the rest are clears
    // and stray commands with random fields. The idling mix changes twice,
    // each time after the block has drained.
    task automatic run_random();
        int unsigned issued;
        int unsigned stored;
        int unsigned burst;
        int unsigned base;
        int unsigned phase;
        logic [1:0]  cmd;
        logic [11:0] index;
        issued = 0;
        stored = 0;
        phase = 0;
        while (issued < RANDOM_ITEMS) begin
            if (phase == 0 && issued >= RANDOM_ITEMS / 3) begin
                wait_drained();
                in_idle_pct = 53;
                out_stall_pct = 30;
                phase = 1;
            end else if (phase == 1 && issued >= 2 * RANDOM_ITEMS / 3) begin
                wait_drained();
                in_idle_pct = 0;
                out_stall_pct = 0;
                phase = 2;
            end
            case ($urandom_range(9))
                0: begin
                    send_item(CMD_CLEAR, 12'($urandom), 16'($urandom));
                    stored = 0;
                    issued++;
                end
                1, 2: begin
                    cmd = 2'($urandom_range(3));
                    send_item(cmd, 12'($urandom), 16'($urandom));
                    if (cmd == CMD_CLEAR)
                        stored = 0;
                    else if (cmd == CMD_APPEND && stored < FRAME_SLOTS)
                        stored++;
                    if (cmd != CMD_UNUSED)
                        issued++;
                end
                default: begin
                    base = $urandom_range(65535);
                    burst = $urandom_range(24, 1);
                    repeat (burst) begin
                        send_item(CMD_APPEND, 12'($urandom), pick_intensity(base));
                        if (stored < FRAME_SLOTS)
                            stored++;
                        issued++;
                    end
                    burst = $urandom_range(12, 1);
                    repeat (burst) begin
                        if ($urandom_range(4) == 0)
                            index = 12'($urandom);
                        else
                            index = 12'($urandom_range(stored - 1));
                        send_item(CMD_READ, index, 16'($urandom));
                        issued++;
                    end
                end
            endcase
        end
    endtask

    initial begin
        sb = new();
        in_idle_pct = 30;
        out_stall_pct = 53;
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_command     <= CMD_CLEAR;
        i_pixel_index <= '0;
        i_intensity   <= '0;
        i_out_ready   <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        // The sender holds off once here until the directed reads are all out.
        wait_drained();
        run_full_frame();
        run_random();

        // Let the last colors come out, then give the block time to show any
        // stray result before judging.
        wait_drained();
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
